>>> hw/rtl/piezo_scan_position_driver_assert.svh
// assertion macros used by the write sequencer of the piezo scan position driver
`ifndef PIEZO_SCAN_POSITION_DRIVER_ASSERT_SVH
`define PIEZO_SCAN_POSITION_DRIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/psp_pkg.sv
// types and constants of the piezo scan position driver
package psp_pkg;

    localparam int TARGET_W = 16;
    localparam int STEP_W   = 16;
    localparam int LINE_W   = 15;
    localparam int DAC_W    = 16;
    localparam int CH_W     = 2;
    localparam int N_WR     = 8;
    localparam int SLOT_W   = 3;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_MAX   = 2'd2;

    // reset values of the configuration registers
    localparam logic [STEP_W-1:0] STEP_SIZE_RST = 16'd1;
    localparam logic [LINE_W-1:0] LINE_SIZE_RST = 15'd256;
    localparam logic [DAC_W-1:0]  DAC_MAX_RST   = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_GOTO          = 3'd0,
        KIND_X_INC         = 3'd1,
        KIND_X_DEC         = 3'd2,
        KIND_NEXT_LINE     = 3'd3,
        KIND_END_LINE      = 3'd4,
        KIND_SET_ORIGIN    = 3'd5,
        KIND_RETURN_ORIGIN = 3'd6
    } kind_t;

    // slots 0..1 x pair, 2..3 y pair, 4..7 z on all channels; channel is slot mod 4
    typedef struct packed {
        logic [N_WR-1:0]             mask;
        logic [N_WR-1:0][DAC_W-1:0]  code;
    } wr_list_t;

endpackage

>>> hw/rtl/psp_cmd_stage.sv
// command register, coordinate update and scaled coordinate differences
module psp_cmd_stage #(
    parameter int COORD_WIDTH = 16,
    parameter int LEVEL_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  psp_pkg::kind_t                    in_kind,
    input  logic signed [psp_pkg::TARGET_W-1:0] in_tx,
    input  logic signed [psp_pkg::TARGET_W-1:0] in_ty,
    input  logic signed [psp_pkg::TARGET_W-1:0] in_tz,
    input  logic [psp_pkg::STEP_W-1:0]        step_size,
    input  logic [psp_pkg::LINE_W-1:0]        line_size,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [LEVEL_WIDTH-1:0]            out_dx,
    output logic [LEVEL_WIDTH-1:0]            out_dy,
    output logic [LEVEL_WIDTH-1:0]            out_dz
);

    localparam int PROD_W = COORD_WIDTH + psp_pkg::STEP_W + 2;

    logic                                  cmd_valid_reg;
    psp_pkg::kind_t                        kind_reg;
    logic signed [psp_pkg::TARGET_W-1:0]   tx_reg, ty_reg, tz_reg;
    logic signed [COORD_WIDTH-1:0]         cx_reg, cy_reg, cz_reg;
    logic signed [COORD_WIDTH-1:0]         cx_next, cy_next, cz_next;
    logic                                  move;
    logic signed [COORD_WIDTH:0]           diff_x, diff_y, diff_z;
    logic signed [PROD_W-1:0]              prod_x, prod_y, prod_z;
    logic signed [psp_pkg::STEP_W:0]       step_s;
    logic                                  diff_valid_reg;
    logic [LEVEL_WIDTH-1:0]                dx_reg, dy_reg, dz_reg;
    logic                                  fire;

    assign fire     = cmd_valid_reg && (!diff_valid_reg || out_ready);
    assign in_ready = !cmd_valid_reg || fire;

    always_comb begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        move    = 1'b1;
        case (kind_reg)
            psp_pkg::KIND_GOTO: begin
                cx_next = COORD_WIDTH'(tx_reg);
                cy_next = COORD_WIDTH'(ty_reg);
                cz_next = COORD_WIDTH'(tz_reg);
            end
            psp_pkg::KIND_X_INC: begin
                cx_next = cx_reg + COORD_WIDTH'(1);
            end
            psp_pkg::KIND_X_DEC: begin
                cx_next = cx_reg - COORD_WIDTH'(1);
            end
            psp_pkg::KIND_NEXT_LINE: begin
                cx_next = '0;
                cy_next = cy_reg + COORD_WIDTH'(1);
            end
            psp_pkg::KIND_END_LINE: begin
                cx_next = COORD_WIDTH'(line_size);
            end
            psp_pkg::KIND_SET_ORIGIN: begin
                cx_next = '0;
                cy_next = '0;
                cz_next = '0;
                move    = 1'b0;
            end
            psp_pkg::KIND_RETURN_ORIGIN: begin
                cx_next = '0;
                cy_next = '0;
                cz_next = '0;
            end
            default: begin
                move = 1'b0;
            end
        endcase
    end

    assign step_s = $signed({1'b0, step_size});
    assign diff_x = $signed({cx_next[COORD_WIDTH-1], cx_next}) - $signed({cx_reg[COORD_WIDTH-1], cx_reg});
    assign diff_y = $signed({cy_next[COORD_WIDTH-1], cy_next}) - $signed({cy_reg[COORD_WIDTH-1], cy_reg});
    assign diff_z = $signed({cz_next[COORD_WIDTH-1], cz_next}) - $signed({cz_reg[COORD_WIDTH-1], cz_reg});
    assign prod_x = diff_x * step_s;
    assign prod_y = diff_y * step_s;
    assign prod_z = diff_z * step_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg  <= 1'b0;
            diff_valid_reg <= 1'b0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            cz_reg         <= '0;
        end else begin
            if (in_ready) begin
                cmd_valid_reg <= in_valid;
            end
            if (fire) begin
                diff_valid_reg <= 1'b1;
                cx_reg         <= cx_next;
                cy_reg         <= cy_next;
                cz_reg         <= cz_next;
            end else if (out_ready) begin
                diff_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            kind_reg <= in_kind;
            tx_reg   <= in_tx;
            ty_reg   <= in_ty;
            tz_reg   <= in_tz;
        end
        if (fire) begin
            dx_reg <= move ? LEVEL_WIDTH'(prod_x) : '0;
            dy_reg <= move ? LEVEL_WIDTH'(prod_y) : '0;
            dz_reg <= move ? LEVEL_WIDTH'(prod_z) : '0;
        end
    end

    assign out_valid = diff_valid_reg;
    assign out_dx    = dx_reg;
    assign out_dy    = dy_reg;
    assign out_dz    = dz_reg;

endmodule

>>> hw/rtl/psp_level_stage.sv
// channel levels, range test and list of dac writes for one command
module psp_level_stage #(
    parameter int LEVEL_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [LEVEL_WIDTH-1:0]        in_dx,
    input  logic [LEVEL_WIDTH-1:0]        in_dy,
    input  logic [LEVEL_WIDTH-1:0]        in_dz,
    input  logic [psp_pkg::DAC_W-1:0]     dac_max,
    output logic                          out_valid,
    input  logic                          out_ready,
    output psp_pkg::wr_list_t             out_list
);

    logic [3:0][LEVEL_WIDTH-1:0] level_reg;
    logic [3:0][LEVEL_WIDTH-1:0] mid, level_next;
    logic [3:0]                  mid_ok, fin_ok;
    logic                        ok_x, ok_y, ok_z;
    logic                        fire;

    function automatic logic lvl_ok(input logic [LEVEL_WIDTH-1:0] v,
                                    input logic [psp_pkg::DAC_W-1:0] m);
        return !v[LEVEL_WIDTH-1] &&
               (v[LEVEL_WIDTH-2:0] <= (LEVEL_WIDTH-1)'(m));
    endfunction

    assign fire      = in_valid && out_ready;
    assign in_ready  = out_ready;
    assign out_valid = in_valid;

    always_comb begin
        mid[0] = level_reg[0] + in_dx;
        mid[1] = level_reg[1] - in_dx;
        mid[2] = level_reg[2] + in_dy;
        mid[3] = level_reg[3] - in_dy;
        for (int i = 0; i < 4; i++) begin
            level_next[i] = mid[i] + in_dz;
            mid_ok[i]     = lvl_ok(mid[i], dac_max);
            fin_ok[i]     = lvl_ok(level_next[i], dac_max);
        end
        ok_x = (in_dx != '0) && mid_ok[0] && mid_ok[1];
        ok_y = (in_dy != '0) && mid_ok[2] && mid_ok[3];
        ok_z = (in_dz != '0) && (&fin_ok);
        out_list.mask = {{4{ok_z}}, {2{ok_y}}, {2{ok_x}}};
        for (int i = 0; i < 4; i++) begin
            out_list.code[i]     = mid[i][psp_pkg::DAC_W-1:0];
            out_list.code[i + 4] = level_next[i][psp_pkg::DAC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else if (fire) begin
            level_reg <= level_next;
        end
    end

endmodule

>>> hw/rtl/psp_write_seq.sv
// result register and output sequencer, one write per cycle while m_tready is high
module psp_write_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load_valid,
    output logic                           load_ready,
    input  psp_pkg::wr_list_t              load_list,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psp_pkg::DAC_W-1:0]      m_tdata,
    output logic [psp_pkg::CH_W-1:0]       m_tuser,
    output logic                           m_tlast
);

    logic [psp_pkg::N_WR-1:0]                     mask_reg, mask_next;
    logic [psp_pkg::N_WR-1:0][psp_pkg::DAC_W-1:0] code_reg;
    logic [psp_pkg::SLOT_W-1:0]                   sel;
    logic [psp_pkg::N_WR-1:0]                     rest;
    logic                                         take, load;

    always_comb begin
        sel = '0;
        for (int i = psp_pkg::N_WR - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = psp_pkg::SLOT_W'(i);
            end
        end
        rest      = mask_reg;
        rest[sel] = 1'b0;
    end

    assign m_tvalid   = |mask_reg;
    assign m_tlast    = (rest == '0);
    assign m_tdata    = code_reg[sel];
    assign m_tuser    = sel[psp_pkg::CH_W-1:0];
    assign take       = m_tvalid && m_tready;
    assign load_ready = !m_tvalid || (take && m_tlast);
    assign load       = load_valid && load_ready;

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = load_list.mask;
        end else if (take) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= load_list.code;
        end
    end

    `include "piezo_scan_position_driver_assert.svh"

    `PSP_ASSERT_NOW(a_last_single, aclk, aresetn, m_tvalid && m_tlast, $onehot(mask_reg), "last item leaves writes behind")
    `PSP_ASSERT_NOW(a_no_overwrite, aclk, aresetn, m_tvalid && !(take && m_tlast), !load_ready, "new list would overwrite pending writes")
    `PSP_ASSERT_NEXT(a_one_per_take, aclk, aresetn, take && !load, $countones(mask_reg) == $countones($past(mask_reg)) - 1, "taken item not retired")

endmodule

>>> hw/rtl/piezo_scan_position_driver.sv
// top level of the piezo scan position driver
// Each command item is registered, its coordinate differences are scaled by step_size in the
// next stage and added to the four channel levels in the stage after; the resulting dac writes
// (none to eight) then leave one per cycle while m_tready is high. The first write is offered
// from the write sequencer's list register, after the command register and the difference
// register. Commands are taken while earlier writes are still being delivered, until the
// command register and the difference register are both full.
module piezo_scan_position_driver #(
    parameter int COORD_WIDTH = 16,
    parameter int LEVEL_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [psp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psp_pkg::DAC_W-1:0]          cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,  // target_x, target_y, target_z
    input  logic [2:0]                         s_tuser,  // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [psp_pkg::DAC_W-1:0]          m_tdata,  // dac_code
    output logic [psp_pkg::CH_W-1:0]           m_tuser,  // channel
    output logic                               m_tlast
);

    logic [psp_pkg::STEP_W-1:0] step_size_reg;
    logic [psp_pkg::LINE_W-1:0] line_size_reg;
    logic [psp_pkg::DAC_W-1:0]  dac_max_reg;

    logic                   diff_valid, diff_ready;
    logic [LEVEL_WIDTH-1:0] dx, dy, dz;
    logic                   list_valid, list_ready;
    psp_pkg::wr_list_t      list;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= psp_pkg::STEP_SIZE_RST;
            line_size_reg <= psp_pkg::LINE_SIZE_RST;
            dac_max_reg   <= psp_pkg::DAC_MAX_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                psp_pkg::CFG_STEP_SIZE: step_size_reg <= cfg_wdata;
                psp_pkg::CFG_LINE_SIZE: line_size_reg <= cfg_wdata[psp_pkg::LINE_W-1:0];
                psp_pkg::CFG_DAC_MAX:   dac_max_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    psp_cmd_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_cmd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (psp_pkg::kind_t'(s_tuser)),
        .in_tx     ($signed(s_tdata[15:0])),
        .in_ty     ($signed(s_tdata[31:16])),
        .in_tz     ($signed(s_tdata[47:32])),
        .step_size (step_size_reg),
        .line_size (line_size_reg),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .out_dx    (dx),
        .out_dy    (dy),
        .out_dz    (dz)
    );

    psp_level_stage #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_level (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .in_dx     (dx),
        .in_dy     (dy),
        .in_dz     (dz),
        .dac_max   (dac_max_reg),
        .out_valid (list_valid),
        .out_ready (list_ready),
        .out_list  (list)
    );

    psp_write_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (list_valid),
        .load_ready (list_ready),
        .load_list  (list),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> tb/sv/piezo_scan_position_driver_test.sv
// self-checking testbench for the piezo scan position driver, predicting each dac write
module piezo_scan_position_driver_test;

    localparam logic [2:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        logic [psp_pkg::CH_W-1:0]  channel;
        logic [psp_pkg::DAC_W-1:0] code;
        logic                      last;
    } dac_write_t;

    class dac_write_scoreboard;
        bit [psp_pkg::STEP_W-1:0] step_size = psp_pkg::STEP_SIZE_RST;
        bit [psp_pkg::LINE_W-1:0] line_size = psp_pkg::LINE_SIZE_RST;
        bit [psp_pkg::DAC_W-1:0]  dac_max   = psp_pkg::DAC_MAX_RST;
        bit signed [15:0]  coord_x;
        bit signed [15:0]  coord_y;
        bit signed [15:0]  coord_z;
        bit [31:0]         level [4];
        dac_write_t        expected_writes[$];
        dac_write_t        cmd_writes[$];
        int unsigned       errors;

        task report_error(string msg);
            $display("error at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(logic [psp_pkg::CFG_IDX_W-1:0] idx,
                                logic [psp_pkg::DAC_W-1:0] value);
            case (idx)
                psp_pkg::CFG_STEP_SIZE: step_size = value;
                psp_pkg::CFG_LINE_SIZE: line_size = value[psp_pkg::LINE_W-1:0];
                psp_pkg::CFG_DAC_MAX:   dac_max = value;
                default: ;
            endcase
        endfunction

        function bit level_ok(bit [31:0] lv);
            return (lv[31] == 1'b0) && (lv <= {16'd0, dac_max});
        endfunction

        function void queue_write(int ch);
            dac_write_t w;
            w.channel = ch[1:0];
            w.code = level[ch][15:0];
            w.last = 1'b0;
            cmd_writes.push_back(w);
        endfunction

        function bit [31:0] scaled(bit signed [15:0] to, bit signed [15:0] from);
            longint dd;
            dd = (longint'(to) - longint'(from)) * longint'(step_size);
            return dd[31:0];
        endfunction

        function void move_pair(int base, bit [31:0] d);
            bit [31:0] p;
            bit [31:0] q;
            p = level[base] + d;
            q = level[base+1] - d;
            level[base] = p;
            level[base+1] = q;
            if (level_ok(p) && level_ok(q)) begin
                queue_write(base);
                queue_write(base + 1);
            end
        endfunction

        function void move_all(bit [31:0] d);
            bit ok;
            ok = 1'b1;
            for (int i = 0; i < 4; i++) begin
                level[i] = level[i] + d;
                if (!level_ok(level[i]))
                    ok = 1'b0;
            end
            if (ok)
                for (int i = 0; i < 4; i++)
                    queue_write(i);
        endfunction

        function void go_to(bit signed [15:0] x, bit signed [15:0] y, bit signed [15:0] z);
            bit [31:0] dx;
            bit [31:0] dy;
            bit [31:0] dz;
            dx = scaled(x, coord_x);
            dy = scaled(y, coord_y);
            dz = scaled(z, coord_z);
            if (dx != 0)
                move_pair(0, dx);
            if (dy != 0)
                move_pair(2, dy);
            if (dz != 0)
                move_all(dz);
            coord_x = x;
            coord_y = y;
            coord_z = z;
        endfunction

        function void note_command(logic [2:0] kind, logic [47:0] targets);
            dac_write_t w;
            cmd_writes.delete();
            case (kind)
                psp_pkg::KIND_GOTO:
                    go_to(targets[15:0], targets[31:16], targets[47:32]);
                psp_pkg::KIND_X_INC:
                    go_to(coord_x + 16'sd1, coord_y, coord_z);
                psp_pkg::KIND_X_DEC:
                    go_to(coord_x - 16'sd1, coord_y, coord_z);
                psp_pkg::KIND_NEXT_LINE:
                    go_to(16'sd0, coord_y + 16'sd1, coord_z);
                psp_pkg::KIND_END_LINE:
                    go_to({1'b0, line_size}, coord_y, coord_z);
                psp_pkg::KIND_SET_ORIGIN: begin
                    coord_x = 16'sd0;
                    coord_y = 16'sd0;
                    coord_z = 16'sd0;
                end
                psp_pkg::KIND_RETURN_ORIGIN:
                    go_to(16'sd0, 16'sd0, 16'sd0);
                default: ;
            endcase
            for (int i = 0; i < cmd_writes.size(); i++) begin
                w = cmd_writes[i];
                w.last = (i == cmd_writes.size() - 1);
                expected_writes.push_back(w);
            end
        endfunction

        task check_write(logic [psp_pkg::CH_W-1:0] ch, logic [psp_pkg::DAC_W-1:0] code,
                         logic last);
            dac_write_t w;
            if (expected_writes.size() == 0) begin
                report_error($sformatf("unexpected write ch %0d code %0h", ch, code));
                return;
            end
            w = expected_writes.pop_front();
            if (ch !== w.channel)
                report_error($sformatf("channel %0d, expected %0d", ch, w.channel));
            if (code !== w.code)
                report_error($sformatf("ch %0d code %0h, expected %0h", w.channel, code, w.code));
            if (last !== w.last)
                report_error($sformatf("ch %0d last %b, expected %b", w.channel, last, w.last));
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [psp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [psp_pkg::DAC_W-1:0]     cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [47:0]                   s_tdata = '0;  // target_x, target_y, target_z
    logic [2:0]                    s_tuser = '0;  // kind
    logic                          m_tvalid;
    logic                          m_tready = 1'b1;
    logic [psp_pkg::DAC_W-1:0]     m_tdata;       // dac_code
    logic [psp_pkg::CH_W-1:0]      m_tuser;       // channel
    logic                          m_tlast;

    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    bit hold_out_req = 1'b0;

    dac_write_scoreboard sb = new;

    piezo_scan_position_driver u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function int unsigned gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function logic [47:0] pack_targets(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    // result side: random stalls, and one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_out_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                m_tready <= 1'b1;
                hold_out_req = 1'b0;
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_write(m_tuser, m_tdata, m_tlast);

    task send_command(logic [2:0] kind, logic [47:0] targets);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= targets;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_command(kind, targets);
        if (src_idle && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    task write_reg(logic [psp_pkg::CFG_IDX_W-1:0] idx, logic [psp_pkg::DAC_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task wait_all_written();
        int unsigned n;
        n = 0;
        s_tvalid <= 1'b0;
        while (sb.expected_writes.size() != 0 && n < 20000) begin
            @(posedge aclk);
            n++;
        end
        if (sb.expected_writes.size() != 0) begin
            sb.report_error($sformatf("%0d writes never arrived", sb.expected_writes.size()));
            sb.expected_writes.delete();
        end
        // commands without writes may still be in the pipeline
        repeat (12) @(posedge aclk);
    endtask

    task send_random_command(int centre);
        logic [2:0]  kind;
        logic [47:0] targets;
        int unsigned roll;
        int          tx;
        int          ty;
        int          tz;
        roll = $urandom_range(0, 99);
        targets = 48'({$urandom, $urandom});
        if (roll < 10) begin
            kind = psp_pkg::KIND_GOTO;
        end else if (roll < 22) begin
            kind = psp_pkg::KIND_GOTO;
            tx = int'($urandom_range(0, 32)) - 16;
            ty = int'($urandom_range(0, 32)) - 16;
            tz = centre + int'($urandom_range(0, 4)) - 2;
            targets = pack_targets(tx, ty, tz);
        end else if (roll < 45) begin
            kind = psp_pkg::KIND_X_INC;
        end else if (roll < 68) begin
            kind = psp_pkg::KIND_X_DEC;
        end else if (roll < 78) begin
            kind = psp_pkg::KIND_NEXT_LINE;
        end else if (roll < 86) begin
            kind = psp_pkg::KIND_END_LINE;
        end else if (roll < 89) begin
            kind = psp_pkg::KIND_SET_ORIGIN;
        end else if (roll < 95) begin
            kind = psp_pkg::KIND_RETURN_ORIGIN;
        end else begin
            kind = KIND_UNUSED;
        end
        send_command(kind, targets);
    endtask

    initial begin
        logic [psp_pkg::DAC_W-1:0] step_v;
        logic [psp_pkg::DAC_W-1:0] line_v;
        logic [psp_pkg::DAC_W-1:0] dac_v;
        int                        centre;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset configuration
        send_command(psp_pkg::KIND_X_INC, pack_targets(0, 0, 0));
        send_command(psp_pkg::KIND_GOTO, pack_targets(0, 0, 1000));
        send_command(psp_pkg::KIND_X_INC, 48'hFFFF_FFFF_FFFF);
        send_command(psp_pkg::KIND_X_DEC, pack_targets(0, 0, 0));
        send_command(psp_pkg::KIND_END_LINE, pack_targets(0, 0, 0));
        send_command(psp_pkg::KIND_NEXT_LINE, pack_targets(0, 0, 0));
        send_command(psp_pkg::KIND_SET_ORIGIN, pack_targets(0, 0, 0));
        send_command(psp_pkg::KIND_RETURN_ORIGIN, pack_targets(0, 0, 0));
        send_command(psp_pkg::KIND_GOTO, pack_targets(32767, -32768, 0));
        send_command(psp_pkg::KIND_GOTO, pack_targets(-32768, 32767, -32768));
        send_command(psp_pkg::KIND_GOTO, pack_targets(-1, -1, -1));
        send_command(KIND_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_command(psp_pkg::KIND_RETURN_ORIGIN, pack_targets(0, 0, 0));
        send_command(psp_pkg::KIND_GOTO, pack_targets(0, 0, 32767));
        send_command(psp_pkg::KIND_GOTO, pack_targets(100, -100, 32767));
        send_command(psp_pkg::KIND_X_DEC, pack_targets(0, 0, 0));
        send_command(psp_pkg::KIND_NEXT_LINE, pack_targets(0, 0, 0));
        send_command(psp_pkg::KIND_RETURN_ORIGIN, pack_targets(0, 0, 0));

        for (int phase = 0; phase < 8; phase++) begin
            wait_all_written();
            case (phase)
                0: begin step_v = 16'hFFFF; line_v = 16'h7FFF; dac_v = 16'hFFFF; end
                1: begin step_v = 16'd0;    line_v = 16'd0;    dac_v = 16'd1;    end
                2: begin step_v = 16'd1;    line_v = 16'd64;   dac_v = 16'hFFFF; end
                3: begin step_v = 16'd3;    line_v = 16'd1000; dac_v = 16'd0;    end
                default: begin
                    case ($urandom_range(0, 2))
                        0: step_v = 16'd1;
                        1: step_v = 16'($urandom_range(1, 16));
                        default: step_v = 16'($urandom_range(0, 65535));
                    endcase
                    line_v = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 64))
                                                         : 16'($urandom_range(0, 32767));
                    dac_v = ($urandom_range(0, 1) == 0) ? 16'hFFFF
                                                        : 16'($urandom_range(0, 65535));
                end
            endcase
            write_reg(psp_pkg::CFG_STEP_SIZE, step_v);
            write_reg(psp_pkg::CFG_LINE_SIZE, line_v);
            write_reg(psp_pkg::CFG_DAC_MAX, dac_v);

            if (step_v == 0)
                centre = 0;
            else
                centre = (int'(dac_v) / 2) / int'(step_v);
            if (centre > 32767)
                centre = 32767;

            src_idle = (phase % 3 != 0);
            sink_idle = (phase % 3 != 0);
            send_command(psp_pkg::KIND_GOTO, pack_targets(0, 0, centre));
            for (int i = 0; i < 60; i++) begin
                if (phase == 2 && i == 10) begin
                    hold_out_req = 1'b1;
                    src_idle = 1'b0;
                end
                if (phase == 2 && i == 34)
                    src_idle = 1'b1;
                if (phase == 3 && i == 30)
                    wait_all_written();
                send_random_command(centre);
            end
        end

        wait_all_written();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
